>>> hw/rtl/pid_controller_filtered_macros.svh
// ----------------------------------------------------------------------------
// pid controller assertion macros
// concurrent check wrappers, clocked on clk and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_FILTERED_MACROS_SVH
`define PID_CONTROLLER_FILTERED_MACROS_SVH

`ifndef SYNTHESIS
// condition must hold at every clock edge
`define PIDF_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pidf assertion failed");
// consequent must hold in the cycle after the antecedent
`define PIDF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidf assertion failed");
`else
`define PIDF_ASSERT(lbl, cond)
`define PIDF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/pidf_pkg.sv
// ----------------------------------------------------------------------------
// pidf_pkg
// shared widths, register codes and saturation helper for the pid controller
// ----------------------------------------------------------------------------
package pidf_pkg;

    localparam int WORD_W = 32;
    localparam int DT_W   = 20;
    localparam int RC_W   = 16;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;
    localparam int DIVN_W = 54;
    localparam int DIVR_W = 21;
    localparam int MODE_W = 11;
    localparam int LIM_W  = 31;
    localparam int TMAG_W = 51;
    localparam int TREM_W = 22;

    localparam logic [DIVR_W-1:0] US_PER_S = 21'd1000000;
    // floor(2^51 / 1000000)
    localparam logic [WORD_W-1:0] US_RECIP = 32'd2251799813;

    typedef logic [2:0] reg_addr_t;

    localparam reg_addr_t REG_PROP_GAIN  = 3'd0;
    localparam reg_addr_t REG_INTEG_GAIN = 3'd1;
    localparam reg_addr_t REG_DERIV_GAIN = 3'd2;
    localparam reg_addr_t REG_OUT_LIMIT  = 3'd3;
    localparam reg_addr_t REG_INT_BOUND  = 3'd4;
    localparam reg_addr_t REG_DEAD_ZONE  = 3'd5;
    localparam reg_addr_t REG_MODE       = 3'd6;
    localparam reg_addr_t REG_FILTER_TC  = 3'd7;

    localparam int MB_INTEG = 0;
    localparam int MB_ILIM  = 1;
    localparam int MB_TRAP  = 2;
    localparam int MB_DFILT = 3;
    localparam int MB_OFILT = 4;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v[PROD_W-1:WORD_W-1] == {(PROD_W-WORD_W+1){v[PROD_W-1]}})
            r = v[WORD_W-1:0];
        else if (v[PROD_W-1])
            r = {1'b1, {(WORD_W-1){1'b0}}};
        else
            r = {1'b0, {(WORD_W-1){1'b1}}};
        return r;
    endfunction

endpackage

>>> hw/rtl/pid_controller_filtered.sv
// ----------------------------------------------------------------------------
// pid_controller_filtered
// Q16.16 pid controller, derivative on measured speed, cascaded low-pass
// filters on D and on the output. A clear item or a held item (no time gone
// by in a timed mode) goes straight to S_OUT, which registers its result
// onto the output. A compute item runs its P, D and integral products, the
// integral adding a reciprocal multiply and up to two correction steps to
// divide by a million, then each filter stage that runs; each stage waits
// on the shared divider, which yields one quotient bit a cycle over 54 bits.
// One shared 33x33 multiplier serves every product. Items are taken one at a
// time; the next item is accepted while a finished result still waits on
// out_stall, and a new result is only issued once the one before it has been
// taken.
// ----------------------------------------------------------------------------
`include "pid_controller_filtered_macros.svh"

module pid_controller_filtered
    import pidf_pkg::*;
#(
    parameter int MAX_FILTER_ORDER = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     kind,
    input  logic signed [WORD_W-1:0] setpoint,
    input  logic signed [WORD_W-1:0] feedback,
    input  logic signed [WORD_W-1:0] feedback_rate,
    input  logic [DT_W-1:0]          elapsed_us,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WORD_W-1:0] drive,
    output logic                     held
);

    localparam int IDX_W = (MAX_FILTER_ORDER > 1) ? $clog2(MAX_FILTER_ORDER) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_P, S_D, S_E, S_Q, S_T, S_TDIV, S_R, S_M, S_C, S_TWAIT, S_AW,
        S_FX, S_FS, S_FDIV, S_FWAIT, S_SUM, S_FIN, S_OUT
    } state_t;

    // configuration
    logic signed [WORD_W-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [LIM_W-1:0]         out_limit_reg, int_bound_reg, dead_zone_reg;
    logic [MODE_W-1:0]        mode_reg;
    logic [WORD_W-1:0]        filter_tc_reg;

    // controller state
    logic signed [WORD_W-1:0] isum_reg, prev_err_reg, last_drive_reg;
    logic signed [WORD_W-1:0] dstage_reg [MAX_FILTER_ORDER];
    logic signed [WORD_W-1:0] ostage_reg [MAX_FILTER_ORDER];

    // working registers
    state_t                   state_reg;
    logic                     sel_reg;
    logic [2:0]               idx_reg;
    logic                     outside_reg;
    logic signed [WORD_W-1:0] err_reg, p_reg, d_reg, q_reg, x_reg, rate_reg;
    logic [DT_W-1:0]          dt_reg;
    logic signed [33:0]       term_reg;
    logic signed [PROD_W-1:0] prod_reg, acc_reg;
    logic                     out_valid_reg, held_reg, res_held_reg;
    logic signed [WORD_W-1:0] drive_reg, res_drive_reg;
    logic                     tneg_reg;
    logic [TMAG_W-1:0]        tmag_reg;
    logic [WORD_W-1:0]        tq_reg;
    logic [TREM_W-1:0]        trem_reg;

    // decoded configuration
    logic [2:0]  d_ord, o_ord, cur_ord;
    logic [RC_W-1:0] d_rc, o_rc, cur_rc;
    logic        d_run, o_run, timed;

    logic [2:0] raw_d_ord, raw_o_ord;

    assign raw_d_ord = mode_reg[7:5];
    assign raw_o_ord = mode_reg[10:8];
    assign d_ord  = (raw_d_ord > 3'(MAX_FILTER_ORDER)) ? 3'(MAX_FILTER_ORDER) : raw_d_ord;
    assign o_ord  = (raw_o_ord > 3'(MAX_FILTER_ORDER)) ? 3'(MAX_FILTER_ORDER) : raw_o_ord;
    assign d_rc   = filter_tc_reg[31:16];
    assign o_rc   = filter_tc_reg[15:0];
    assign d_run  = mode_reg[MB_DFILT] && (d_rc != '0) && (d_ord != '0);
    assign o_run  = mode_reg[MB_OFILT] && (o_rc != '0) && (o_ord != '0);
    assign timed  = mode_reg[MB_INTEG] || mode_reg[MB_DFILT] || mode_reg[MB_OFILT];
    assign cur_ord = sel_reg ? o_ord : d_ord;
    assign cur_rc  = sel_reg ? o_rc : d_rc;

    // apb port
    logic      cfg_wr;
    reg_addr_t cfg_addr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_addr = paddr[4:2];

    always_comb
    begin
        case (cfg_addr)
            REG_PROP_GAIN:  prdata = prop_gain_reg;
            REG_INTEG_GAIN: prdata = integ_gain_reg;
            REG_DERIV_GAIN: prdata = deriv_gain_reg;
            REG_OUT_LIMIT:  prdata = {1'b0, out_limit_reg};
            REG_INT_BOUND:  prdata = {1'b0, int_bound_reg};
            REG_DEAD_ZONE:  prdata = {1'b0, dead_zone_reg};
            REG_MODE:       prdata = {21'b0, mode_reg};
            REG_FILTER_TC:  prdata = filter_tc_reg;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
            out_limit_reg  <= '0;
            int_bound_reg  <= '0;
            dead_zone_reg  <= '0;
            mode_reg       <= '0;
            filter_tc_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_addr)
                REG_PROP_GAIN:  prop_gain_reg  <= pwdata;
                REG_INTEG_GAIN: integ_gain_reg <= pwdata;
                REG_DERIV_GAIN: deriv_gain_reg <= pwdata;
                REG_OUT_LIMIT:  out_limit_reg  <= pwdata[LIM_W-1:0];
                REG_INT_BOUND:  int_bound_reg  <= pwdata[LIM_W-1:0];
                REG_DEAD_ZONE:  dead_zone_reg  <= pwdata[LIM_W-1:0];
                REG_MODE:       mode_reg       <= pwdata[MODE_W-1:0];
                REG_FILTER_TC:  filter_tc_reg  <= pwdata;
                default:        ;
            endcase
        end
    end

    // shared multiplier operand select
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [MUL_W-1:0] e_sum, e_adj, e_val;
    logic signed [WORD_W-1:0] stage_rd;

    assign stage_rd = sel_reg ? ostage_reg[idx_reg[IDX_W-1:0]]
                              : dstage_reg[idx_reg[IDX_W-1:0]];

    always_comb
    begin
        e_sum = MUL_W'(err_reg) + MUL_W'(prev_err_reg);
        // halve toward zero
        e_adj = e_sum + $signed({32'b0, e_sum[MUL_W-1]});
        e_val = mode_reg[MB_TRAP] ? (e_adj >>> 1) : MUL_W'(err_reg);
    end

    always_comb
    begin
        case (state_reg)
            S_P:
            begin
                mul_a = MUL_W'(prop_gain_reg);
                mul_b = MUL_W'(err_reg);
            end
            S_D:
            begin
                mul_a = MUL_W'(deriv_gain_reg);
                mul_b = MUL_W'(rate_reg);
            end
            S_E:
            begin
                mul_a = MUL_W'(integ_gain_reg);
                mul_b = e_val;
            end
            S_T:
            begin
                mul_a = MUL_W'(q_reg);
                mul_b = $signed({13'b0, dt_reg});
            end
            S_R:
            begin
                // quotient estimate, never above the true quotient
                mul_a = $signed({1'b0, tmag_reg[TMAG_W-1:TMAG_W-WORD_W]});
                mul_b = $signed({1'b0, US_RECIP});
            end
            S_M:
            begin
                mul_a = $signed({1'b0, prod_reg[2*WORD_W-1:WORD_W]});
                mul_b = $signed({12'b0, US_PER_S});
            end
            S_FX:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = $signed({13'b0, dt_reg});
            end
            S_FS:
            begin
                mul_a = MUL_W'(stage_rd);
                mul_b = $signed({17'b0, cur_rc});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // shared divider, filter stages only
    logic                     div_start, div_done;
    logic signed [DIVN_W-1:0] div_num, div_q;
    logic [DIVR_W-1:0]        div_den;
    logic signed [PROD_W-1:0] num_sum;

    assign num_sum   = acc_reg + prod_reg;
    assign div_start = (state_reg == S_FDIV);
    assign div_num   = num_sum[DIVN_W-1:0];
    assign div_den   = DIVR_W'(cur_rc) + DIVR_W'(dt_reg);

    pidf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // error on accept
    logic signed [WORD_W:0]   diff;
    logic signed [WORD_W-1:0] err_in;
    logic                     in_acc;

    assign in_acc = in_valid && !in_stall;
    assign diff   = (WORD_W+1)'(setpoint) - (WORD_W+1)'(feedback);
    assign err_in = sat32(PROD_W'(diff));

    // dead zone test
    logic [WORD_W:0] abs_err;
    assign abs_err = err_reg[WORD_W-1] ? (WORD_W+1)'(-(WORD_W+1)'(err_reg))
                                       : (WORD_W+1)'(err_reg);

    // anti-windup and integral clamp
    logic signed [36:0] aw_prop, aw_abs, aw_term, aw_s1, aw_lim, aw_bnd, aw_isum;
    logic               aw_same;
    logic signed [WORD_W-1:0] isum_new;

    always_comb
    begin
        aw_isum = 37'(isum_reg);
        aw_lim  = $signed({6'b0, out_limit_reg});
        aw_bnd  = $signed({6'b0, int_bound_reg});
        aw_prop = 37'(p_reg) + aw_isum + 37'(term_reg) + 37'(d_reg);
        aw_abs  = aw_prop[36] ? -aw_prop : aw_prop;
        aw_same = (err_reg > 0 && isum_reg > 0) || (err_reg < 0 && isum_reg < 0);
        aw_term = 37'(term_reg);
        if (mode_reg[MB_ILIM])
        begin
            if (out_limit_reg != '0 && aw_abs > aw_lim && aw_same)
                aw_term = '0;
            aw_s1 = aw_isum + aw_term;
            if (aw_s1 > aw_bnd)
                aw_term = aw_bnd - aw_isum;
            else if (aw_s1 < -aw_bnd)
                aw_term = -aw_bnd - aw_isum;
        end
        else
        begin
            aw_s1 = '0;
        end
        isum_new = sat32(PROD_W'(aw_isum + aw_term));
    end

    // output clamp and sum
    logic signed [WORD_W:0]   lim_x, x_ext;
    logic signed [WORD_W-1:0] drive_clamped, sum_sat, stage_new;

    always_comb
    begin
        lim_x = $signed({2'b0, out_limit_reg});
        x_ext = (WORD_W+1)'(x_reg);
        drive_clamped = x_reg;
        if (out_limit_reg != '0)
        begin
            if (x_ext > lim_x)
                drive_clamped = lim_x[WORD_W-1:0];
            else if (x_ext < -lim_x)
                drive_clamped = WORD_W'(-lim_x);
        end
        sum_sat   = sat32(PROD_W'(p_reg) + PROD_W'(isum_reg) + PROD_W'(x_reg));
        stage_new = sat32(PROD_W'(div_q));
    end

    logic signed [PROD_W-1:0] prod_neg;
    logic [2:0]               o_last;
    logic [TMAG_W-1:0]        rem_full;
    assign prod_neg = -prod_reg;
    assign o_last   = o_ord - 3'd1;
    assign rem_full = tmag_reg - prod_reg[TMAG_W-1:0];

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            sel_reg        <= 1'b0;
            idx_reg        <= '0;
            isum_reg       <= '0;
            prev_err_reg   <= '0;
            last_drive_reg <= '0;
            outside_reg    <= 1'b0;
            err_reg        <= '0;
            p_reg          <= '0;
            d_reg          <= '0;
            q_reg          <= '0;
            x_reg          <= '0;
            rate_reg       <= '0;
            dt_reg         <= '0;
            term_reg       <= '0;
            acc_reg        <= '0;
            held_reg       <= 1'b0;
            res_held_reg   <= 1'b0;
            drive_reg      <= '0;
            res_drive_reg  <= '0;
            tneg_reg       <= 1'b0;
            tmag_reg       <= '0;
            tq_reg         <= '0;
            trem_reg       <= '0;
            for (int i = 0; i < MAX_FILTER_ORDER; i++)
            begin
                dstage_reg[i] <= '0;
                ostage_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        err_reg  <= err_in;
                        rate_reg <= feedback_rate;
                        dt_reg   <= elapsed_us;
                        if (kind)
                        begin
                            isum_reg       <= '0;
                            prev_err_reg   <= '0;
                            last_drive_reg <= '0;
                            for (int i = 0; i < MAX_FILTER_ORDER; i++)
                            begin
                                dstage_reg[i] <= '0;
                                ostage_reg[i] <= '0;
                            end
                            res_drive_reg <= '0;
                            res_held_reg  <= 1'b0;
                            state_reg     <= S_OUT;
                        end
                        else if (timed && elapsed_us == '0)
                        begin
                            res_drive_reg <= last_drive_reg;
                            res_held_reg  <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_P;
                        end
                    end
                end
                S_P:
                begin
                    outside_reg <= abs_err > {2'b0, dead_zone_reg};
                    state_reg   <= S_D;
                end
                S_D:
                begin
                    p_reg     <= outside_reg ? sat32(prod_reg >>> 16) : '0;
                    state_reg <= S_E;
                end
                S_E:
                begin
                    d_reg <= sat32(prod_neg >>> 16);
                    x_reg <= sat32(prod_neg >>> 16);
                    if (mode_reg[MB_INTEG] && outside_reg)
                        state_reg <= S_Q;
                    else if (d_run)
                    begin
                        sel_reg   <= 1'b0;
                        idx_reg   <= '0;
                        state_reg <= S_FX;
                    end
                    else
                        state_reg <= S_SUM;
                end
                S_Q:
                begin
                    q_reg     <= sat32(prod_reg >>> 16);
                    state_reg <= S_T;
                end
                S_T:
                begin
                    state_reg <= S_TDIV;
                end
                S_TDIV:
                begin
                    tneg_reg  <= prod_reg[PROD_W-1];
                    tmag_reg  <= prod_reg[PROD_W-1] ? prod_neg[TMAG_W-1:0]
                                                    : prod_reg[TMAG_W-1:0];
                    state_reg <= S_R;
                end
                S_R:
                begin
                    state_reg <= S_M;
                end
                S_M:
                begin
                    tq_reg    <= prod_reg[2*WORD_W-1:WORD_W];
                    state_reg <= S_C;
                end
                S_C:
                begin
                    trem_reg  <= rem_full[TREM_W-1:0];
                    state_reg <= S_TWAIT;
                end
                S_TWAIT:
                begin
                    // estimate is at most two short of the quotient
                    if (trem_reg >= {1'b0, US_PER_S})
                    begin
                        trem_reg <= trem_reg - {1'b0, US_PER_S};
                        tq_reg   <= tq_reg + 32'd1;
                    end
                    else
                    begin
                        term_reg  <= tneg_reg ? -$signed({2'b0, tq_reg})
                                              : $signed({2'b0, tq_reg});
                        state_reg <= S_AW;
                    end
                end
                S_AW:
                begin
                    isum_reg <= isum_new;
                    if (d_run)
                    begin
                        sel_reg   <= 1'b0;
                        idx_reg   <= '0;
                        state_reg <= S_FX;
                    end
                    else
                        state_reg <= S_SUM;
                end
                S_FX:
                begin
                    state_reg <= S_FS;
                end
                S_FS:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_FDIV;
                end
                S_FDIV:
                begin
                    state_reg <= S_FWAIT;
                end
                S_FWAIT:
                begin
                    if (div_done)
                    begin
                        if (sel_reg)
                            ostage_reg[idx_reg[IDX_W-1:0]] <= stage_new;
                        else
                            dstage_reg[idx_reg[IDX_W-1:0]] <= stage_new;
                        x_reg <= stage_new;
                        if (idx_reg + 3'd1 < cur_ord)
                        begin
                            idx_reg   <= idx_reg + 3'd1;
                            state_reg <= S_FX;
                        end
                        else if (sel_reg)
                            state_reg <= S_FIN;
                        else
                            state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    x_reg <= sum_sat;
                    if (o_run)
                    begin
                        sel_reg   <= 1'b1;
                        idx_reg   <= '0;
                        state_reg <= S_FX;
                    end
                    else
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    // clamped output also lands in the last output stage
                    if (o_ord != '0)
                        ostage_reg[o_last[IDX_W-1:0]] <= drive_clamped;
                    last_drive_reg <= drive_clamped;
                    prev_err_reg   <= err_reg;
                    res_drive_reg  <= drive_clamped;
                    res_held_reg   <= 1'b0;
                    state_reg      <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        drive_reg     <= res_drive_reg;
                        held_reg      <= res_held_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign held      = held_reg;

    `PIDF_ASSERT_NEXT(a_clear_zeroes, in_acc && kind, isum_reg == 0 && last_drive_reg == 0)
    `PIDF_ASSERT_NEXT(a_div_multicycle, div_start, !div_done)
    `PIDF_ASSERT_NEXT(a_result_issued, state_reg == S_OUT && !(out_valid_reg && out_stall), out_valid_reg)
    `PIDF_ASSERT(a_stage_index, !(state_reg == S_FWAIT) || (idx_reg < cur_ord))

endmodule

>>> hw/rtl/pidf_div.sv
// ----------------------------------------------------------------------------
// pidf_div
// signed by unsigned restoring divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module pidf_div
    import pidf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DIVN_W-1:0] dividend,
    input  logic        [DIVR_W-1:0] divisor,
    output logic                     done,
    output logic signed [DIVN_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVN_W);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVN_W-1:0] mag_reg;
    logic [DIVR_W:0]   rem_reg;
    logic [DIVR_W-1:0] den_reg;

    logic [DIVR_W:0]   rem_sh;
    logic              ge;
    logic [DIVR_W:0]   rem_next;
    logic [DIVN_W-1:0] mag_next;

    always_comb
    begin
        rem_sh   = {rem_reg[DIVR_W-1:0], mag_reg[DIVN_W-1]};
        ge       = (rem_sh >= {1'b0, den_reg});
        rem_next = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        mag_next = {mag_reg[DIVN_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIVN_W-1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[DIVN_W-1];
            mag_reg <= dividend[DIVN_W-1] ? (~dividend + 1'b1) : dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

endmodule

>>> tb/sv/tb_pid_controller_filtered.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_controller_filtered
// Self-checking bench for the Q16.16 PID controller with filtered D and output.
// Register settings are written over the APB port while the block is idle.
// Items are sent with random gaps on both handshakes. A predictor works out
// drive and held for each accepted item, and a scoreboard compares every
// result with them in order.
// ----------------------------------------------------------------------------
import pidf_pkg::*;

class pid_scoreboard;
    localparam int ORDER_CAP = 4;

    int prop_gain, integ_gain, deriv_gain;
    longint out_limit, int_bound, dead_band, mode, filter_tc;
    int integ_acc, prev_err, last_out;
    int d_stage[ORDER_CAP];
    int o_stage[ORDER_CAP];
    int drive_q[$];
    bit held_q[$];
    int errors;

    function new();
        errors = 0;
        prop_gain = 0; integ_gain = 0; deriv_gain = 0;
        out_limit = 0; int_bound = 0; dead_band = 0; mode = 0; filter_tc = 0;
        clear_state();
    endfunction

    function void clear_state();
        integ_acc = 0; prev_err = 0; last_out = 0;
        for (int i = 0; i < ORDER_CAP; i++)
        begin
            d_stage[i] = 0;
            o_stage[i] = 0;
        end
    endfunction

    function void set_reg(reg_addr_t idx, logic [31:0] v);
        case (idx)
            REG_PROP_GAIN:  prop_gain  = v;
            REG_INTEG_GAIN: integ_gain = v;
            REG_DERIV_GAIN: deriv_gain = v;
            REG_OUT_LIMIT:  out_limit  = v[30:0];
            REG_INT_BOUND:  int_bound  = v[30:0];
            REG_DEAD_ZONE:  dead_band  = v[30:0];
            REG_MODE:       mode       = v[10:0];
            REG_FILTER_TC:  filter_tc  = v;
            default: ;
        endcase
    endfunction

    function int sat(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return int'(v);
    endfunction

    function int qmul(longint a, longint b);
        return sat((a * b) >>> 16);
    endfunction

    function int cap_order(longint o);
        return (o > ORDER_CAP) ? ORDER_CAP : int'(o);
    endfunction

    // one first-order low-pass stage per step of the cascade
    function int run_lowpass(bit on_out, int order, longint rc, longint dt, int x);
        longint s;
        for (int i = 0; i < order; i++)
        begin
            s = on_out ? o_stage[i] : d_stage[i];
            s = sat((longint'(x) * dt + s * rc) / (rc + dt));
            if (on_out)
                o_stage[i] = int'(s);
            else
                d_stage[i] = int'(s);
            x = int'(s);
        end
        return x;
    endfunction

    function void note(bit clr, int sp, int fb, int rate, longint dt);
        int d_ord, o_ord, err, p, d, out;
        longint d_rc, o_rc, aerr, e, term, prop, aprop;
        bit outside, same;
        d_ord = cap_order((mode >> 5) & 7);
        o_ord = cap_order((mode >> 8) & 7);
        d_rc = (filter_tc >> 16) & 16'hffff;
        o_rc = filter_tc & 16'hffff;
        if (clr)
        begin
            clear_state();
            drive_q.push_back(0);
            held_q.push_back(1'b0);
            return;
        end
        if ((mode & 'h19) != 0 && dt == 0)
        begin
            drive_q.push_back(last_out);
            held_q.push_back(1'b1);
            return;
        end
        err = sat(longint'(sp) - longint'(fb));
        aerr = (err < 0) ? -longint'(err) : longint'(err);
        outside = aerr > dead_band;
        p = outside ? qmul(prop_gain, err) : 0;
        d = sat((-(longint'(deriv_gain) * longint'(rate))) >>> 16);
        if (mode[MB_INTEG] && outside)
        begin
            e = mode[MB_TRAP] ? (longint'(err) + longint'(prev_err)) / 2 : longint'(err);
            term = longint'(qmul(integ_gain, e)) * dt / 1000000;
            if (mode[MB_ILIM])
            begin
                prop = longint'(p) + integ_acc + term + d;
                aprop = (prop < 0) ? -prop : prop;
                same = (err > 0 && integ_acc > 0) || (err < 0 && integ_acc < 0);
                if (out_limit > 0 && aprop > out_limit && same)
                    term = 0;
                if (longint'(integ_acc) + term > int_bound)
                    term = int_bound - integ_acc;
                else if (longint'(integ_acc) + term < -int_bound)
                    term = -int_bound - integ_acc;
            end
            integ_acc = sat(longint'(integ_acc) + term);
        end
        if (mode[MB_DFILT] && d_rc > 0 && d_ord > 0)
            d = run_lowpass(1'b0, d_ord, d_rc, dt, d);
        out = sat(longint'(p) + integ_acc + d);
        if (mode[MB_OFILT] && o_rc > 0 && o_ord > 0)
            out = run_lowpass(1'b1, o_ord, o_rc, dt, out);
        if (out_limit > 0)
        begin
            if (out > out_limit)
                out = int'(out_limit);
            else if (out < -out_limit)
                out = int'(-out_limit);
        end
        if (o_ord > 0)
            o_stage[o_ord - 1] = out;
        last_out = out;
        prev_err = err;
        drive_q.push_back(out);
        held_q.push_back(1'b0);
    endfunction

    function void check(int got_drive, bit got_held);
        int exp_drive;
        bit exp_held;
        if (drive_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: drive=%h held=%b", got_drive, got_held);
            return;
        end
        exp_drive = drive_q.pop_front();
        exp_held = held_q.pop_front();
        if (exp_drive !== got_drive || exp_held !== got_held)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: drive exp %h got %h, held exp %b got %b",
                         exp_drive, got_drive, exp_held, got_held);
        end
    endfunction

    function int pending();
        return drive_q.size();
    endfunction
endclass

module tb_pid_controller_filtered;
    localparam longint CYCLE_LIMIT = 6000000;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic in_valid, in_stall;
    logic kind;
    logic signed [WORD_W-1:0] setpoint, feedback, feedback_rate;
    logic [DT_W-1:0] elapsed_us;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [WORD_W-1:0] drive;
    logic held;

    pid_scoreboard sb;
    int tx_idle_pct, rx_idle_pct;
    longint cycles = 0;

    pid_controller_filtered uut (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check(drive, held);

    task automatic reg_write(reg_addr_t idx, logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, v);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic program_all(logic [31:0] pg, logic [31:0] ig, logic [31:0] dg,
                               logic [31:0] lim, logic [31:0] bnd, logic [31:0] dz,
                               logic [31:0] md, logic [31:0] tc);
        // the last item must not be offered again while the settings move
        @(negedge clk);
        in_valid <= 1'b0;
        // every result must be back before the settings move
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        reg_write(REG_PROP_GAIN, pg);
        reg_write(REG_INTEG_GAIN, ig);
        reg_write(REG_DERIV_GAIN, dg);
        reg_write(REG_OUT_LIMIT, lim);
        reg_write(REG_INT_BOUND, bnd);
        reg_write(REG_DEAD_ZONE, dz);
        reg_write(REG_MODE, md);
        reg_write(REG_FILTER_TC, tc);
    endtask

    task automatic send_item(bit k, logic [31:0] sp, logic [31:0] fb,
                             logic [31:0] rate, logic [DT_W-1:0] dt);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        setpoint <= sp;
        feedback <= fb;
        feedback_rate <= rate;
        elapsed_us <= dt;
        do
            @(posedge clk);
        while (in_stall);
        sb.note(k, sp, fb, rate, dt);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2, 3: return $urandom_range(0, 32'h40000) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_mag();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'h7fffffff;
            2: return $urandom_range(0, 32'h1000000);
            default: return {1'b0, 31'($urandom_range(0, 32'h7fffffff))};
        endcase
    endfunction

    function automatic logic [31:0] pick_tc();
        logic [15:0] a, b;
        a = ($urandom_range(0, 5) == 0) ? 16'hffff : 16'($urandom);
        b = ($urandom_range(0, 5) == 0) ? 16'h0 : 16'($urandom_range(1, 2000));
        return $urandom_range(0, 1) ? {a, b} : {b, a};
    endfunction

    task automatic random_item();
        logic [31:0] sp, fb, rate;
        logic [DT_W-1:0] dt;
        bit k;
        k = ($urandom_range(0, 99) < 4);
        // mostly nearby values so that the loop settles into real behaviour
        if ($urandom_range(0, 3) != 0)
        begin
            fb = $urandom_range(0, 32'h2000000) - 32'h1000000;
            sp = fb + $urandom_range(0, 32'h200000) - 32'h100000;
            rate = $urandom_range(0, 32'h100000) - 32'h80000;
        end
        else
        begin
            sp = $urandom;
            fb = $urandom;
            rate = $urandom;
        end
        case ($urandom_range(0, 9))
            0: dt = '0;
            1: dt = '1;
            2: dt = DT_W'($urandom);
            default: dt = DT_W'($urandom_range(1, 5000));
        endcase
        send_item(k, sp, fb, rate, dt);
    endtask

    initial
    begin
        logic [31:0] md;
        sb = new();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; kind = 1'b0;
        setpoint = '0; feedback = '0; feedback_rate = '0; elapsed_us = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // all features on, both filters running
        md = (3 << 8) | (2 << 5) | 11'h1f;
        program_all(32'h10000, 32'h20000, 32'h8000, 32'h640000, 32'h320000,
                    32'h1000, md, (32'd100 << 16) | 32'd200);
        send_item(1'b1, 32'h0, 32'h0, 32'h0, 20'd100);
        send_item(1'b0, 32'h10000, 32'h0, 32'h0, 20'd0);
        send_item(1'b0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 20'd1000);
        send_item(1'b0, 32'h80000000, 32'h7fffffff, 32'h80000000, 20'd1000);
        send_item(1'b0, 32'h800, 32'h0, 32'h0, 20'd500);
        send_item(1'b0, 32'h50000, 32'h0, 32'h10000, 20'hfffff);
        send_item(1'b0, 32'h50000, 32'h10000, 32'hffff0000, 20'd1);
        send_item(1'b0, 32'h0, 32'h50000, 32'h0, 20'd0);
        send_item(1'b0, 32'h30000, 32'h0, 32'h0, 20'd2000);
        send_item(1'b1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 20'hfffff);
        send_item(1'b0, 32'h30000, 32'h0, 32'h0, 20'd2000);

        // untimed, output order set but its filter off, no clamp
        md = (7 << 8) | (7 << 5) | (1 << MB_ILIM) | (1 << MB_TRAP);
        program_all(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h0, 32'h7fffffff,
                    32'h0, md, 32'hffffffff);
        send_item(1'b0, 32'h7fffffff, 32'h80000000, 32'h80000000, 20'd0);
        send_item(1'b0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 20'd77);
        send_item(1'b0, 32'h0, 32'h0, 32'h0, 20'd0);

        // integral with a tight clamp and a wide dead band
        md = (1 << MB_INTEG) | (1 << MB_ILIM) | (4 << 8) | (1 << MB_OFILT);
        program_all(32'h20000, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'h10000,
                    32'h7fffffff, md, 32'h0000ffff);
        send_item(1'b0, 32'h7fffffff, 32'h0, 32'h0, 20'd10);
        send_item(1'b0, 32'h10000, 32'h0, 32'h0, 20'd10);
        send_item(1'b0, 32'h10000, 32'h0, 32'h0, 20'd0);

        for (int ph = 0; ph < 12; ph++)
        begin
            tx_idle_pct = (ph < 4) ? 11 : (ph < 8) ? 54 : 0;
            rx_idle_pct = (ph < 4) ? 54 : (ph < 8) ? 11 : 0;
            md = $urandom_range(0, 2047);
            // keep the cascades short for most settings
            if ($urandom_range(0, 2) != 0)
                md = (md & 11'h31f) | (11'($urandom_range(0, 2)) << 5)
                     | (11'($urandom_range(0, 2)) << 8);
            if (ph == 3)
                md = 11'h7ff;
            program_all(pick_gain(), pick_gain(), pick_gain(), pick_mag(),
                        pick_mag(), ($urandom_range(0, 1) ? 32'h0 : pick_mag() >> 8),
                        md, pick_tc());
            for (int n = 0; n < 162; n++)
                random_item();
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
